### src/register_vm_execute_unit_defines.svh
// Assertion macros shared by the execute unit modules.
// Needs i_clk and i_rst_n in the module that expands them.
`ifndef REGISTER_VM_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_VM_EXECUTE_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define RVM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define RVM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

### src/rvm_pkg.sv
// Shared types, opcodes, status codes and register indexes of the execute unit.
// No dependencies.
package rvm_pkg;

    localparam int REG_COUNT_DEF = 32;
    localparam int MEM_WORDS_DEF = 1024;
    localparam int STEP_WORDS    = 4;
    localparam int EPOCH_W       = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV      = 2'd2;

    localparam logic [4:0] OP_HALT    = 5'd0;
    localparam logic [4:0] OP_ADD     = 5'd1;
    localparam logic [4:0] OP_SUB     = 5'd2;
    localparam logic [4:0] OP_MUL     = 5'd3;
    localparam logic [4:0] OP_DIV     = 5'd4;
    localparam logic [4:0] OP_MOV     = 5'd5;
    localparam logic [4:0] OP_MOVI    = 5'd6;
    localparam logic [4:0] OP_DBGDUMP = 5'd7;
    localparam logic [4:0] OP_WRMEM   = 5'd8;
    localparam logic [4:0] OP_LOAD    = 5'd9;
    localparam logic [4:0] OP_JMP     = 5'd10;
    localparam logic [4:0] OP_JEQ     = 5'd11;
    localparam logic [4:0] OP_JNEQ    = 5'd12;
    localparam logic [4:0] OP_JGT     = 5'd13;
    localparam logic [4:0] OP_JLT     = 5'd14;
    localparam logic [4:0] OP_CMP     = 5'd15;
    localparam logic [4:0] OP_SETNE   = 5'd16;
    localparam logic [4:0] OP_SETGE   = 5'd17;
    localparam logic [4:0] OP_SETLE   = 5'd18;

    localparam logic [2:0] STS_RUN     = 3'd0;
    localparam logic [2:0] STS_EXIT    = 3'd1;
    localparam logic [2:0] STS_BADREG  = 3'd2;
    localparam logic [2:0] STS_BADADDR = 3'd3;
    localparam logic [2:0] STS_BADJMP  = 3'd4;
    localparam logic [2:0] STS_PRIV    = 3'd5;
    localparam logic [2:0] STS_BADCALL = 3'd6;
    localparam logic [2:0] STS_BADOP   = 3'd7;

    localparam logic [2:0] PRIV_NO_DEBUG = 3'd4;

    typedef struct packed {
        logic [4:0]  mode;
        logic [63:0] arg_first;
        logic [63:0] arg_second;
        logic [63:0] arg_third;
    } t_in_item;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [2:0]  status;
        logic        debug_valid;
        logic [4:0]  debug_reg;
        logic [63:0] debug_value;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

    typedef struct packed {
        logic        we;
        logic [7:0]  idx;
        logic [63:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic        we;
        logic        re;
        logic [15:0] addr;
        logic [63:0] wdata;
    } t_dm_req;

endpackage

### src/rvm_rf.sv
// Register file: two registered read ports, one write port, valid bits for reset.
// Depends on rvm_pkg.
module rvm_rf
    import rvm_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF,
    localparam int RIW = (REG_COUNT > 2) ? $clog2(REG_COUNT) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_re,
    input  logic [RIW-1:0] i_ra,
    input  logic [RIW-1:0] i_rb,
    input  t_rf_wr         i_wr,
    output logic [63:0]    o_qa,
    output logic [63:0]    o_qb
);

    logic [63:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [63:0]          r_qa;
    logic [63:0]          r_qb;
    logic                 r_va;
    logic                 r_vb;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.idx[RIW-1:0]] <= i_wr.data;
        end
        if (i_re) begin
            r_qa <= mem[i_ra];
            r_qb <= mem[i_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.idx[RIW-1:0]] <= 1'b1;
            end
            if (i_re) begin
                r_va <= r_valid[i_ra];
                r_vb <= r_valid[i_rb];
            end
        end
    end

    assign o_qa = r_va ? r_qa : '0;
    assign o_qb = r_vb ? r_qb : '0;

endmodule

### src/rvm_dmem.sv
// Data memory with a per-word run epoch tag; tag sweep after reset and on epoch wrap.
// Depends on rvm_pkg.
module rvm_dmem
    import rvm_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    localparam int AW = $clog2(MEM_WORDS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dm_req            i_req,
    input  logic [EPOCH_W-1:0] i_epoch,
    input  logic               i_clr_start,
    output logic               o_busy,
    output logic [63:0]        o_rdata,
    output logic               o_hit
);

    logic [63:0]        mem_d [MEM_WORDS];
    logic [EPOCH_W-1:0] mem_t [MEM_WORDS];
    logic [63:0]        r_rd;
    logic [EPOCH_W-1:0] r_rt;
    logic               r_busy;
    logic [AW-1:0]      r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem_d[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (r_busy) begin
            mem_t[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            mem_t[i_req.addr[AW-1:0]] <= i_epoch;
        end
        if (i_req.re) begin
            r_rd <= mem_d[i_req.addr[AW-1:0]];
            r_rt <= mem_t[i_req.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MEM_WORDS - 1)) begin
                r_busy     <= 1'b0;
                r_clr_addr <= '0;
            end
        end else if (i_clr_start) begin
            r_busy <= 1'b1;
        end
    end

    assign o_busy  = r_busy;
    assign o_rdata = r_rd;
    assign o_hit   = (r_rt == i_epoch);

    `include "register_vm_execute_unit_defines.svh"

    `RVM_NEVER(a_dm_access_clr, r_busy && (i_req.we || i_req.re), "memory access during sweep")
    `RVM_CHECK(a_dm_sweep_end, r_busy && r_clr_addr == AW'(MEM_WORDS - 1) |=> !r_busy, "sweep overrun")

endmodule

### src/rvm_muldiv.sv
// Shared multi-cycle multiply (32x32 partial products) and restoring divide.
// Depends on rvm_pkg.
module rvm_muldiv
    import rvm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_md_req     i_req,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_result
);

    logic        r_busy;
    logic        r_done;
    logic        r_is_div;
    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_res;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic [63:0] n_rem;
    logic [63:0] n_quo;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                mul_a = r_x[31:0];
                mul_b = r_y[31:0];
            end
            2'd1: begin
                mul_a = r_x[31:0];
                mul_b = r_y[63:32];
            end
            default: begin
                mul_a = r_x[63:32];
                mul_b = r_y[31:0];
            end
        endcase
        shifted = {r_rem, r_quo[63]};
        diff    = shifted - {1'b0, r_y};
        if (!diff[64]) begin
            n_rem = diff[63:0];
            n_quo = {r_quo[62:0], 1'b1};
        end else begin
            n_rem = shifted[63:0];
            n_quo = {r_quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_rem <= '0;
            r_quo <= i_x;
        end else if (r_busy) begin
            if (r_is_div) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == 6'd63) begin
                    r_res <= (r_y == '0) ? '0 : n_quo;
                end
            end else begin
                r_prod <= mul_a * mul_b;
                case (r_cnt[1:0])
                    2'd0: r_acc <= r_acc;
                    2'd1: r_acc <= r_prod;
                    default: r_acc <= r_acc + {r_prod[31:0], 32'd0};
                endcase
                if (r_cnt[1:0] == 2'd3) begin
                    r_res <= r_acc + {r_prod[31:0], 32'd0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_is_div <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_is_div <= i_req.is_div;
                r_cnt    <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if ((r_is_div && r_cnt == 6'd63) || (!r_is_div && r_cnt == 6'd3)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_res;

    `include "register_vm_execute_unit_defines.svh"

    `RVM_NEVER(a_md_restart, i_req.start && r_busy, "start while busy")
    `RVM_CHECK(a_md_done_idle, r_done |-> !r_busy, "done while still busy")

endmodule

### src/register_vm_execute_unit.sv
// Top level of the register machine execute unit: sequencer, checks, output register.
// Depends on rvm_pkg, rvm_rf, rvm_dmem, rvm_muldiv and the assertion header.
// One instruction per transfer, one result per instruction. Add, subtract, compares, moves,
// jumps, store, vmcall and halt pass from input transfer to result through register file
// read, execute and write back; load adds a data memory read; multiply takes four steps of
// the shared 32x32 multiplier; divide produces one quotient bit a cycle in the shared
// divider. After reset, and after every 255th run, the data memory tag sweep holds off input
// transfers until every tag is cleared. The next item is taken once the result is in the
// output register, even while that result still waits for its transfer.
module register_vm_execute_unit
    import rvm_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int RIW = (REG_COUNT > 2) ? $clog2(REG_COUNT) : 1;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MD   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [15:0]        r_code_size;
    logic [10:0]        r_mem_size;
    logic [2:0]         r_priv;
    logic [2:0]         r_state;
    logic [15:0]        r_pc;
    logic               r_running;
    logic [EPOCH_W-1:0] r_epoch;
    logic [4:0]         r_op;
    logic [63:0]        r_a1;
    logic [63:0]        r_a2;
    logic [63:0]        r_a3;
    logic [2:0]         r_status;
    logic [15:0]        r_npc;
    logic               r_we;
    logic [7:0]         r_widx;
    logic [63:0]        r_res;
    logic               r_dbg_v;
    logic [63:0]        r_dbg_val;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [63:0] rf_qa;
    logic [63:0] rf_qb;
    t_rf_wr      rf_wr;
    t_dm_req     dm_req;
    logic        dm_busy;
    logic [63:0] dm_rdata;
    logic        dm_hit;
    t_md_req     md_req;
    logic        md_busy;
    logic        md_done;
    logic [63:0] md_result;

    logic        accept;
    logic        out_free;
    logic        clr_start;
    logic [63:0] lim;
    logic [15:0] pc_adv;
    logic        at_end;
    logic        npc_end;
    logic        ok1;
    logic        ok2;
    logic        ok3;
    logic [2:0]  e_status;
    logic [15:0] e_npc;
    logic        e_we;
    logic [7:0]  e_widx;
    logic [63:0] e_res;
    logic        e_dbg;
    logic        e_md;
    logic        e_store;
    logic        e_load;
    logic [2:0]  fin;

    assign o_in_ready = (r_state == S_IDLE) && !dm_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        lim     = (32'(r_mem_size) > 32'(MEM_WORDS)) ? 64'(MEM_WORDS) : 64'(r_mem_size);
        pc_adv  = r_pc + 16'(STEP_WORDS);
        at_end  = (17'(r_pc) + 17'(STEP_WORDS - 1)) >= 17'(r_code_size);
        npc_end = (17'(r_npc) + 17'(STEP_WORDS - 1)) >= 17'(r_code_size);
        ok1     = r_a1 < 64'(REG_COUNT);
        ok2     = r_a2 < 64'(REG_COUNT);
        ok3     = r_a3 < 64'(REG_COUNT);
        e_status = STS_RUN;
        e_npc    = pc_adv;
        e_we     = 1'b0;
        e_widx   = r_a1[7:0];
        e_res    = '0;
        e_dbg    = 1'b0;
        e_md     = 1'b0;
        e_store  = 1'b0;
        e_load   = 1'b0;
        if (at_end) begin
            e_status = STS_EXIT;
        end else begin
            case (r_op)
                OP_HALT: e_status = STS_EXIT;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_SETNE, OP_SETGE, OP_SETLE: begin
                    if (!(ok1 && ok2 && ok3)) begin
                        e_status = STS_BADREG;
                    end else begin
                        e_we = 1'b1;
                        case (r_op)
                            OP_ADD:   e_res = rf_qa + rf_qb;
                            OP_SUB:   e_res = rf_qa - rf_qb;
                            OP_CMP:   e_res = 64'(rf_qa == rf_qb);
                            OP_SETNE: e_res = 64'(rf_qa != rf_qb);
                            OP_SETGE: e_res = 64'(rf_qa >= rf_qb);
                            OP_SETLE: e_res = 64'(rf_qa <= rf_qb);
                            default: begin
                                e_we = 1'b0;
                                e_md = 1'b1;
                            end
                        endcase
                    end
                end
                OP_MOV: begin
                    if (!ok1 || !ok2) begin
                        e_status = STS_BADREG;
                    end else begin
                        e_we  = 1'b1;
                        e_res = rf_qa;
                    end
                end
                OP_MOVI: begin
                    if (!ok1) begin
                        e_status = STS_BADREG;
                    end else begin
                        e_we  = 1'b1;
                        e_res = r_a2;
                    end
                end
                OP_DBGDUMP: begin
                    if (r_priv == PRIV_NO_DEBUG) begin
                        e_status = STS_PRIV;
                    end else if (r_a1 != '0) begin
                        e_status = STS_BADCALL;
                    end else if (!ok2) begin
                        e_status = STS_BADREG;
                    end else begin
                        e_dbg = 1'b1;
                    end
                end
                OP_WRMEM: begin
                    if (!ok1) begin
                        e_status = STS_BADREG;
                    end else if (r_a2 >= lim) begin
                        e_status = STS_BADADDR;
                    end else begin
                        e_store = 1'b1;
                    end
                end
                OP_LOAD: begin
                    e_widx = r_a2[7:0];
                    if (!ok2) begin
                        e_status = STS_BADREG;
                    end else if (r_a1 >= lim) begin
                        e_status = STS_BADADDR;
                    end else begin
                        e_load = 1'b1;
                    end
                end
                OP_JMP, OP_JEQ, OP_JNEQ, OP_JGT, OP_JLT: begin
                    if (r_a1 >= 64'(r_code_size)) begin
                        e_status = STS_BADJMP;
                    end else if (r_op == OP_JMP) begin
                        e_npc = r_a1[15:0];
                    end else if (!ok2 || !ok3) begin
                        e_status = STS_BADREG;
                    end else begin
                        case (r_op)
                            OP_JEQ:  e_npc = (rf_qa == rf_qb) ? r_a1[15:0] : pc_adv;
                            OP_JNEQ: e_npc = (rf_qa != rf_qb) ? r_a1[15:0] : pc_adv;
                            OP_JGT:  e_npc = (rf_qa > rf_qb) ? r_a1[15:0] : pc_adv;
                            default: e_npc = (rf_qa < rf_qb) ? r_a1[15:0] : pc_adv;
                        endcase
                    end
                end
                default: e_status = STS_BADOP;
            endcase
        end
        fin = (r_status == STS_RUN && npc_end) ? STS_EXIT : r_status;
    end

    assign clr_start = (r_state == S_WB) && out_free && (fin != STS_RUN) && (r_epoch == '1);

    always_comb begin
        rf_wr.we   = (r_state == S_WB) && out_free && r_we;
        rf_wr.idx  = r_widx;
        rf_wr.data = r_res;
        dm_req.we    = (r_state == S_EXEC) && e_store;
        dm_req.re    = (r_state == S_EXEC) && e_load;
        dm_req.addr  = e_store ? r_a2[15:0] : r_a1[15:0];
        dm_req.wdata = rf_qa;
        md_req.start  = (r_state == S_EXEC) && e_md;
        md_req.is_div = (r_op == OP_DIV);
    end

    rvm_rf #(.REG_COUNT(REG_COUNT)) u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (r_state == S_IDLE),
        .i_ra    ((i_in_data.mode == OP_WRMEM) ? i_in_data.arg_first[RIW-1:0]
                                               : i_in_data.arg_second[RIW-1:0]),
        .i_rb    (i_in_data.arg_third[RIW-1:0]),
        .i_wr    (rf_wr),
        .o_qa    (rf_qa),
        .o_qb    (rf_qb)
    );

    rvm_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (dm_req),
        .i_epoch     (r_epoch),
        .i_clr_start (clr_start),
        .o_busy      (dm_busy),
        .o_rdata     (dm_rdata),
        .o_hit       (dm_hit)
    );

    rvm_muldiv u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_x      (rf_qa),
        .i_y      (rf_qb),
        .o_busy   (md_busy),
        .o_done   (md_done),
        .o_result (md_result)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_in_data.mode;
            r_a1 <= i_in_data.arg_first;
            r_a2 <= i_in_data.arg_second;
            r_a3 <= i_in_data.arg_third;
        end
        case (r_state)
            S_EXEC: begin
                r_status  <= e_status;
                r_npc     <= e_npc;
                r_we      <= e_we;
                r_widx    <= e_widx;
                r_res     <= e_res;
                r_dbg_v   <= e_dbg;
                r_dbg_val <= rf_qa;
            end
            S_MD: begin
                if (md_done) begin
                    r_res <= md_result;
                    r_we  <= 1'b1;
                end
            end
            S_LOAD: begin
                r_res <= dm_hit ? dm_rdata : '0;
                r_we  <= 1'b1;
            end
            default: begin
            end
        endcase
        if ((r_state == S_WB) && out_free) begin
            r_out.next_pc     <= (fin == STS_RUN) ? r_npc : '0;
            r_out.status      <= fin;
            r_out.debug_valid <= r_dbg_v;
            r_out.debug_reg   <= r_dbg_v ? r_a2[4:0] : '0;
            r_out.debug_value <= r_dbg_v ? r_dbg_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_size <= '0;
            r_mem_size  <= 11'd1024;
            r_priv      <= '0;
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_running   <= 1'b0;
            r_epoch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CODE_SIZE: r_code_size <= i_cfg_data;
                    CFG_MEM_SIZE:  r_mem_size  <= i_cfg_data[10:0];
                    CFG_PRIV:      r_priv      <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                        if (!r_running) begin
                            r_pc      <= '0;
                            r_running <= 1'b1;
                            r_epoch   <= r_epoch + EPOCH_W'(1);
                        end
                    end
                end
                S_EXEC: begin
                    if (e_status != STS_RUN) begin
                        r_state <= S_WB;
                    end else if (e_md) begin
                        r_state <= S_MD;
                    end else if (e_load) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        r_state <= S_WB;
                    end
                end
                S_LOAD: r_state <= S_WB;
                S_WB: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        r_pc        <= (fin == STS_RUN) ? r_npc : '0;
                        r_running   <= (fin == STS_RUN);
                        if (clr_start) begin
                            r_epoch <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `include "register_vm_execute_unit_defines.svh"

    `RVM_CHECK(a_end_pc_zero, o_out_valid && o_out_data.status != STS_RUN |-> o_out_data.next_pc == '0, "ended run with nonzero pc")
    `RVM_CHECK(a_dbg_status, o_out_valid && o_out_data.debug_valid |-> (o_out_data.status == STS_RUN || o_out_data.status == STS_EXIT), "debug dump with error")
    `RVM_NEVER(a_md_wait_idle, r_state == S_MD && !md_busy && !md_done, "waiting on idle divider")
    `RVM_CHECK(a_not_running_pc, !r_running |-> r_pc == '0, "stale pc outside a run")

endmodule
